### rtl/yprc_pkg.sv
// ============================================================================
// yprc_pkg: shared types and constants for the camera pose update block
// Command and result records, operation codes, angle constants, back-end states.
// ============================================================================
`default_nettype none

package yprc_pkg;

    localparam int OFFSET_W  = 9;
    localparam int SPEED_W   = 24;
    localparam int SENS_W    = 16;
    localparam int DELTA_W   = 18;
    localparam int YAW_W     = 17;
    localparam int PITCH_W   = 16;
    localparam int POS_W     = 32;
    localparam int VEC_W     = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SENS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z = 2'd3;

    localparam logic [SENS_W-1:0] SENS_RESET = 16'd6554;

    // angles in 1/256 degree
    localparam logic [YAW_W-1:0] DEG45_Q8  = 17'd11520;
    localparam logic [YAW_W-1:0] DEG90_Q8  = 17'd23040;
    localparam logic [YAW_W-1:0] DEG180_Q8 = 17'd46080;
    localparam logic [YAW_W-1:0] DEG270_Q8 = 17'd69120;
    localparam logic [YAW_W-1:0] DEG360_Q8 = 17'd92160;
    localparam logic signed [DELTA_W-1:0] PITCH_LIMIT_Q8 = 18'sd22784;

    // pi/180 in Q32
    localparam logic [26:0] RAD_PER_DEG_Q32 = 27'd74961321;

    localparam logic [3:0] K_LAST = 4'd10;

    localparam logic signed [VEC_W-1:0] VEC_ZERO    = 16'sd0;
    localparam logic signed [VEC_W-1:0] VEC_NEG_ONE = -16'sd32767;

    typedef enum logic [2:0] {
        OP_ROTATE   = 3'd0,
        OP_UP       = 3'd1,
        OP_DOWN     = 3'd2,
        OP_LEFT     = 3'd3,
        OP_RIGHT    = 3'd4,
        OP_FORWARD  = 3'd5,
        OP_BACKWARD = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [DELTA_W-1:0]  dyaw;
        logic signed [DELTA_W-1:0]  dpitch;
        logic signed [SPEED_W-1:0]  speed;
    } cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [VEC_W-1:0]   front_x;
        logic signed [VEC_W-1:0]   front_y;
        logic signed [VEC_W-1:0]   front_z;
        logic [YAW_W-1:0]          yaw;
        logic signed [PITCH_W-1:0] pitch;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_TSTART,
        ST_XMUL,
        ST_XCAP,
        ST_PMUL,
        ST_DMUL1,
        ST_DMUL2,
        ST_DFIX,
        ST_TDONE,
        ST_FX,
        ST_FZ,
        ST_VEC,
        ST_MC,
        ST_MS,
        ST_MAPPLY,
        ST_RESULT
    } bst_t;

endpackage

`default_nettype wire

### rtl/yaw_pitch_camera_pose_update.sv
// ============================================================================
// yaw_pitch_camera_pose_update: first-person camera pose keeper
// Rotates yaw/pitch from mouse offsets, moves the position along view axes.
// ============================================================================
// Usage:
//   Input side is a queue: drive mode/x_offset/y_offset/speed with push; a
//   transaction is taken when push is high and full is low. Two commands can
//   wait in the front queue while the back end works.
//   Result side is a queue: while empty is low the pose after the oldest
//   command is on pos_*, front_*, yaw_out and pitch_out; pop takes it.
//   Every command gives exactly one result, in order.
//   A rotate runs two sin/cos series of nine power terms; each term takes a
//   power, a reciprocal and a remainder product on the one shared multiplier,
//   then a correct-and-accumulate step. Side, forward and backward moves pass
//   through ST_MC, ST_MS and ST_MAPPLY, up/down through ST_MAPPLY only, and
//   an ignored mode goes straight to ST_RESULT.
//   The back end handles one command at a time and picks up the next one
//   the cycle after its result has moved into the output register.
//   Reset puts the camera at the origin, yaw 270 degrees, pitch 0, looking
//   down -z. Writing start_x/y/z loads that coordinate at once; write the
//   configuration only while nothing is in flight.
//   When pop stays low the result is held and the back end stalls after its
//   next command; the front queue keeps accepting until it fills.
// ============================================================================
`default_nettype none

module yaw_pitch_camera_pose_update #(
    parameter int TRIG_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [2:0]                             mode,
    input  logic signed [yprc_pkg::OFFSET_W-1:0]   x_offset,
    input  logic signed [yprc_pkg::OFFSET_W-1:0]   y_offset,
    input  logic signed [yprc_pkg::SPEED_W-1:0]    speed,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [yprc_pkg::POS_W-1:0]      pos_x,
    output logic signed [yprc_pkg::POS_W-1:0]      pos_y,
    output logic signed [yprc_pkg::POS_W-1:0]      pos_z,
    output logic signed [yprc_pkg::VEC_W-1:0]      front_x,
    output logic signed [yprc_pkg::VEC_W-1:0]      front_y,
    output logic signed [yprc_pkg::VEC_W-1:0]      front_z,
    output logic [yprc_pkg::YAW_W-1:0]             yaw_out,
    output logic signed [yprc_pkg::PITCH_W-1:0]    pitch_out,
    input  logic                                   cfg_we,
    input  logic [yprc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [yprc_pkg::CFG_W-1:0]             cfg_data
);
    import yprc_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;
    res_t res;
    logic res_valid;
    logic res_take;
    res_t out_reg;
    logic out_valid_reg;
    logic out_valid_next;

    yprc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .x_offset  (x_offset),
        .y_offset  (y_offset),
        .speed     (speed),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    yprc_back #(
        .TRIG_BITS (TRIG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res),
        .res_valid (res_valid),
        .res_take  (res_take)
    );

    // output register frees up in the same cycle it is popped
    assign res_take = !out_valid_reg || pop;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_reg <= res;
        end
    end

    assign empty     = !out_valid_reg;
    assign pos_x     = out_reg.pos_x;
    assign pos_y     = out_reg.pos_y;
    assign pos_z     = out_reg.pos_z;
    assign front_x   = out_reg.front_x;
    assign front_y   = out_reg.front_y;
    assign front_z   = out_reg.front_z;
    assign yaw_out   = out_reg.yaw;
    assign pitch_out = out_reg.pitch;

`ifndef SYNTH
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pitch_out <= 16'sd22784 && pitch_out >= -16'sd22784))
        else $error("pitch out of clamp range");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (yaw_out < 17'd92160))
        else $error("yaw not wrapped");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> res_valid)
        else $error("back end dropped a pending result");
`endif

endmodule

`default_nettype wire

### rtl/yprc_front.sv
// ============================================================================
// yprc_front: input side of the camera pose update block
// Takes input transactions, scales mouse offsets into angle deltas and queues
// decoded commands for the back end in a two-entry queue.
// ============================================================================
`default_nettype none

module yprc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [2:0]                            mode,
    input  logic signed [yprc_pkg::OFFSET_W-1:0]  x_offset,
    input  logic signed [yprc_pkg::OFFSET_W-1:0]  y_offset,
    input  logic signed [yprc_pkg::SPEED_W-1:0]   speed,
    input  logic                                  cfg_we,
    input  logic [yprc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [yprc_pkg::CFG_W-1:0]            cfg_data,
    output yprc_pkg::cmd_t                        cmd,
    output logic                                  cmd_valid,
    input  logic                                  cmd_take
);
    import yprc_pkg::*;

    logic [SENS_W-1:0] sens_reg;
    cmd_t              q_mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              do_push;
    logic              do_pop;
    cmd_t              cmd_in;

    // round(offset * sensitivity / 256), half away from zero
    function automatic logic signed [DELTA_W-1:0] scale_offset(
        input logic signed [OFFSET_W-1:0] off,
        input logic [SENS_W-1:0]          sens
    );
        logic signed [25:0] prod;
        logic [25:0]        mag;
        logic [DELTA_W-1:0] rnd;
        prod = off * $signed({1'b0, sens});
        mag  = prod[25] ? 26'(-prod) : 26'(prod);
        rnd  = DELTA_W'((mag + 26'd128) >> 8);
        return prod[25] ? -$signed(rnd) : $signed(rnd);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg <= SENS_RESET;
        end
        else if (cfg_we && cfg_index == REG_SENS)
        begin
            sens_reg <= cfg_data[SENS_W-1:0];
        end
    end

    always_comb
    begin
        cmd_in.op     = op_t'(mode);
        cmd_in.dyaw   = scale_offset(x_offset, sens_reg);
        cmd_in.dpitch = scale_offset(y_offset, sens_reg);
        cmd_in.speed  = speed;
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/yprc_back.sv
// ============================================================================
// yprc_back: execution side of the camera pose update block
// Holds the pose, runs sin/cos series on one shared multiplier and applies moves.
// ============================================================================
`default_nettype none

module yprc_back #(
    parameter int TRIG_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  yprc_pkg::cmd_t                  cmd,
    input  logic                            cmd_valid,
    output logic                            cmd_take,
    input  logic                            cfg_we,
    input  logic [yprc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [yprc_pkg::CFG_W-1:0]      cfg_data,
    output yprc_pkg::res_t                  res,
    output logic                            res_valid,
    input  logic                            res_take
);
    import yprc_pkg::*;

    localparam int F  = TRIG_BITS;
    localparam int MW = (F + 3 > 28) ? F + 3 : 28;
    localparam int PW = 2 * MW;
    localparam int AW = F + 2;
    localparam int NT = 11;

    // series divisors k!, reciprocal shifts F+1+clog2(k!) and reciprocals
    localparam logic [21:0] DIV [NT] = '{22'd1, 22'd1, 22'd2, 22'd6, 22'd24, 22'd120,
                                         22'd720, 22'd5040, 22'd40320, 22'd362880,
                                         22'd3628800};
    localparam int SH [NT] = '{F + 1, F + 1, F + 2, F + 4, F + 6, F + 8, F + 11,
                               F + 14, F + 17, F + 20, F + 23};
    localparam logic [63:0] RECIP [NT] = '{
        (64'd1 << (F + 1)),
        (64'd1 << (F + 1)),
        (64'd1 << (F + 2)) / 64'd2,
        (64'd1 << (F + 4)) / 64'd6,
        (64'd1 << (F + 6)) / 64'd24,
        (64'd1 << (F + 8)) / 64'd120,
        (64'd1 << (F + 11)) / 64'd720,
        (64'd1 << (F + 14)) / 64'd5040,
        (64'd1 << (F + 17)) / 64'd40320,
        (64'd1 << (F + 20)) / 64'd362880,
        (64'd1 << (F + 23)) / 64'd3628800
    };

    bst_t                       state_reg;
    bst_t                       state_next;
    cmd_t                       cmd_reg;
    logic [YAW_W-1:0]           yaw_reg;
    logic signed [PITCH_W-1:0]  pitch_reg;
    logic signed [POS_W-1:0]    pos_x_reg;
    logic signed [POS_W-1:0]    pos_y_reg;
    logic signed [POS_W-1:0]    pos_z_reg;
    logic signed [VEC_W-1:0]    front_x_reg;
    logic signed [VEC_W-1:0]    front_y_reg;
    logic signed [VEC_W-1:0]    front_z_reg;
    logic signed [VEC_W-1:0]    hc_reg;
    logic signed [VEC_W-1:0]    hs_reg;

    logic                       pass_reg;
    logic [3:0]                 k_reg;
    logic [13:0]                r_reg;
    logic [1:0]                 quad_reg;
    logic                       swap_reg;
    logic [F-1:0]               x_reg;
    logic [F-1:0]               p_reg;
    logic [F-1:0]               q0_reg;
    logic signed [AW-1:0]       sin_acc_reg;
    logic signed [AW-1:0]       cos_acc_reg;
    logic signed [AW-1:0]       sy_reg;
    logic signed [AW-1:0]       cy_reg;
    logic signed [AW-1:0]       sp_reg;
    logic signed [AW-1:0]       cp_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [24:0]         dc_reg;

    logic signed [MW-1:0]       mul_a;
    logic signed [MW-1:0]       mul_b;
    logic [PW-1:0]              shifted;
    logic [F-1:0]               p_new;
    logic [F-1:0]               q0_new;
    logic [F-1:0]               x_new;
    logic [PW-1:0]              rem;
    logic [F-1:0]               q_term;
    logic                       term_neg;
    logic [YAW_W-1:0]           pitch_mag;
    logic [YAW_W-1:0]           ang;
    logic [YAW_W-1:0]           ang_rem;
    logic [1:0]                 quad_new;
    logic [13:0]                r_new;
    logic                       swap_new;
    logic signed [AW-1:0]       sr;
    logic signed [AW-1:0]       cr;
    logic signed [AW-1:0]       s_val;
    logic signed [AW-1:0]       c_val;
    logic signed [18:0]         yaw_sum;
    logic signed [DELTA_W-1:0]  pitch_sum;
    logic signed [24:0]         ds;
    logic signed [24:0]         sp25;

    // value with frac fraction bits to Q1.15, rounded half away, saturated
    function automatic logic signed [VEC_W-1:0] to_q15(
        input logic signed [PW-1:0] v,
        input int                   frac
    );
        logic [PW-1:0]    mag;
        logic [PW-1:0]    m;
        logic [VEC_W-1:0] sat;
        mag = v[PW-1] ? PW'(-v) : PW'(v);
        if (frac > 15)
        begin
            m = (mag + (PW'(1) << (frac - 16))) >> (frac - 15);
        end
        else
        begin
            m = mag << (15 - frac);
        end
        sat = (m > PW'(32767)) ? 16'd32767 : m[VEC_W-1:0];
        return v[PW-1] ? -$signed(sat) : $signed(sat);
    endfunction

    function automatic logic signed [24:0] round_q15(input logic signed [PW-1:0] v);
        logic [PW-1:0] mag;
        logic [PW-1:0] m;
        mag = v[PW-1] ? PW'(-v) : PW'(v);
        m   = (mag + PW'(16384)) >> 15;
        return v[PW-1] ? -$signed(m[24:0]) : $signed(m[24:0]);
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] a,
        input logic signed [24:0]      d
    );
        logic signed [POS_W:0] s;
        s = 33'(a) + 33'(d);
        if (s > 33'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (s < -33'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return s[POS_W-1:0];
    endfunction

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_ROTATE:                              state_next = ST_ANGLE;
                        OP_UP, OP_DOWN:                         state_next = ST_MAPPLY;
                        OP_LEFT, OP_RIGHT, OP_FORWARD, OP_BACKWARD:
                                                                state_next = ST_MC;
                        OP_NONE:                                state_next = ST_RESULT;
                    endcase
                end
            end
            ST_ANGLE:  state_next = ST_TSTART;
            ST_TSTART: state_next = ST_XMUL;
            ST_XMUL:   state_next = ST_XCAP;
            ST_XCAP:   state_next = ST_PMUL;
            ST_PMUL:   state_next = ST_DMUL1;
            ST_DMUL1:  state_next = ST_DMUL2;
            ST_DMUL2:  state_next = ST_DFIX;
            ST_DFIX:   state_next = (k_reg == K_LAST) ? ST_TDONE : ST_PMUL;
            ST_TDONE:  state_next = pass_reg ? ST_FX : ST_TSTART;
            ST_FX:     state_next = ST_FZ;
            ST_FZ:     state_next = ST_VEC;
            ST_VEC:    state_next = ST_RESULT;
            ST_MC:     state_next = ST_MS;
            ST_MS:     state_next = ST_MAPPLY;
            ST_MAPPLY: state_next = ST_RESULT;
            ST_RESULT: state_next = res_take ? ST_IDLE : ST_RESULT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs and multiplier operands ----------------
    always_comb
    begin
        cmd_take  = (state_reg == ST_IDLE) && cmd_valid;
        res_valid = (state_reg == ST_RESULT);
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_XMUL:
            begin
                mul_a = MW'(r_reg);
                mul_b = MW'(RAD_PER_DEG_Q32);
            end
            ST_PMUL:
            begin
                mul_a = MW'(p_reg);
                mul_b = MW'(x_reg);
            end
            ST_DMUL1:
            begin
                mul_a = MW'(p_new);
                mul_b = MW'(RECIP[k_reg]);
            end
            ST_DMUL2:
            begin
                mul_a = MW'(q0_new);
                mul_b = MW'(DIV[k_reg]);
            end
            ST_FX:
            begin
                mul_a = MW'(cy_reg);
                mul_b = MW'(cp_reg);
            end
            ST_FZ:
            begin
                mul_a = MW'(sy_reg);
                mul_b = MW'(cp_reg);
            end
            ST_MC:
            begin
                mul_a = MW'(cmd_reg.speed);
                mul_b = MW'(hc_reg);
            end
            ST_MS:
            begin
                mul_a = MW'(cmd_reg.speed);
                mul_b = MW'(hs_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- datapath helpers ----------------
    always_comb
    begin
        shifted  = PW'(prod_reg) >> SH[k_reg];
        p_new    = prod_reg[F +: F];
        q0_new   = shifted[F-1:0];
        x_new    = F'((PW'(prod_reg) + (PW'(1) << (39 - F))) >> (40 - F));
        rem      = PW'(p_reg) - PW'(prod_reg);
        q_term   = q0_reg + F'(rem >= PW'(DIV[k_reg]));
        term_neg = (k_reg[1:0] == 2'd2) || (k_reg[1:0] == 2'd3);

        pitch_mag = YAW_W'(pitch_reg[PITCH_W-1] ? -pitch_reg : pitch_reg);
        ang       = pass_reg ? pitch_mag : yaw_reg;
        priority if (ang >= DEG270_Q8)
        begin
            quad_new = 2'd3;
            ang_rem  = ang - DEG270_Q8;
        end
        else if (ang >= DEG180_Q8)
        begin
            quad_new = 2'd2;
            ang_rem  = ang - DEG180_Q8;
        end
        else if (ang >= DEG90_Q8)
        begin
            quad_new = 2'd1;
            ang_rem  = ang - DEG90_Q8;
        end
        else
        begin
            quad_new = 2'd0;
            ang_rem  = ang;
        end
        // fold into 0..45 degrees by complement
        swap_new = (ang_rem > DEG45_Q8);
        r_new    = swap_new ? 14'(DEG90_Q8 - ang_rem) : ang_rem[13:0];

        sr = swap_reg ? cos_acc_reg : sin_acc_reg;
        cr = swap_reg ? sin_acc_reg : cos_acc_reg;
        unique case (quad_reg)
            2'd0:
            begin
                s_val = sr;
                c_val = cr;
            end
            2'd1:
            begin
                s_val = cr;
                c_val = -sr;
            end
            2'd2:
            begin
                s_val = -sr;
                c_val = -cr;
            end
            default:
            begin
                s_val = -cr;
                c_val = sr;
            end
        endcase

        yaw_sum   = $signed({2'b00, yaw_reg}) + 19'(cmd_reg.dyaw);
        pitch_sum = DELTA_W'(pitch_reg) + cmd_reg.dpitch;
        if (yaw_sum <= 19'sd0)
        begin
            yaw_sum = yaw_sum + $signed({2'b00, DEG360_Q8});
        end
        if (yaw_sum >= $signed({2'b00, DEG360_Q8}))
        begin
            yaw_sum = yaw_sum - $signed({2'b00, DEG360_Q8});
        end
        if (pitch_sum > PITCH_LIMIT_Q8)
        begin
            pitch_sum = PITCH_LIMIT_Q8;
        end
        if (pitch_sum < -PITCH_LIMIT_Q8)
        begin
            pitch_sum = -PITCH_LIMIT_Q8;
        end

        ds   = round_q15(prod_reg);
        sp25 = 25'(cmd_reg.speed);
    end

    // ---------------- pose state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            yaw_reg     <= DEG270_Q8;
            pitch_reg   <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            front_x_reg <= VEC_ZERO;
            front_y_reg <= VEC_ZERO;
            front_z_reg <= VEC_NEG_ONE;
            hc_reg      <= VEC_ZERO;
            hs_reg      <= VEC_NEG_ONE;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ANGLE)
            begin
                yaw_reg   <= yaw_sum[YAW_W-1:0];
                pitch_reg <= pitch_sum[PITCH_W-1:0];
            end
            if (state_reg == ST_FZ)
            begin
                front_x_reg <= to_q15(prod_reg, 2 * F);
            end
            if (state_reg == ST_VEC)
            begin
                front_z_reg <= to_q15(prod_reg, 2 * F);
                front_y_reg <= to_q15(PW'(sp_reg), F);
                hc_reg      <= to_q15(PW'(cy_reg), F);
                hs_reg      <= to_q15(PW'(sy_reg), F);
            end
            if (state_reg == ST_MAPPLY)
            begin
                unique case (cmd_reg.op)
                    OP_UP:       pos_y_reg <= sat_add(pos_y_reg, sp25);
                    OP_DOWN:     pos_y_reg <= sat_add(pos_y_reg, -sp25);
                    OP_LEFT:
                    begin
                        pos_x_reg <= sat_add(pos_x_reg, ds);
                        pos_z_reg <= sat_add(pos_z_reg, -dc_reg);
                    end
                    OP_RIGHT:
                    begin
                        pos_x_reg <= sat_add(pos_x_reg, -ds);
                        pos_z_reg <= sat_add(pos_z_reg, dc_reg);
                    end
                    OP_FORWARD:
                    begin
                        pos_x_reg <= sat_add(pos_x_reg, dc_reg);
                        pos_z_reg <= sat_add(pos_z_reg, ds);
                    end
                    OP_BACKWARD:
                    begin
                        pos_x_reg <= sat_add(pos_x_reg, -dc_reg);
                        pos_z_reg <= sat_add(pos_z_reg, -ds);
                    end
                    default:
                    begin
                        pos_x_reg <= pos_x_reg;
                    end
                endcase
            end
            // start registers load the position directly
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_X: pos_x_reg <= $signed(cfg_data);
                    REG_START_Y: pos_y_reg <= $signed(cfg_data);
                    REG_START_Z: pos_z_reg <= $signed(cfg_data);
                    default:     pos_x_reg <= pos_x_reg;
                endcase
            end
        end
    end

    // ---------------- scratch registers ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        unique case (state_reg)
            ST_ANGLE:
            begin
                pass_reg <= 1'b0;
            end
            ST_TSTART:
            begin
                r_reg    <= r_new;
                quad_reg <= quad_new;
                swap_reg <= swap_new;
            end
            ST_XCAP:
            begin
                x_reg       <= x_new;
                p_reg       <= x_new;
                k_reg       <= 4'd1;
                sin_acc_reg <= AW'(x_new);
                cos_acc_reg <= AW'(1) <<< F;
            end
            ST_PMUL:
            begin
                k_reg <= k_reg + 4'd1;
            end
            ST_DMUL1:
            begin
                p_reg <= p_new;
            end
            ST_DMUL2:
            begin
                q0_reg <= q0_new;
            end
            ST_DFIX:
            begin
                if (k_reg[0])
                begin
                    sin_acc_reg <= term_neg ? sin_acc_reg - AW'(q_term)
                                            : sin_acc_reg + AW'(q_term);
                end
                else
                begin
                    cos_acc_reg <= term_neg ? cos_acc_reg - AW'(q_term)
                                            : cos_acc_reg + AW'(q_term);
                end
            end
            ST_TDONE:
            begin
                if (pass_reg)
                begin
                    sp_reg <= pitch_reg[PITCH_W-1] ? -s_val : s_val;
                    cp_reg <= c_val;
                end
                else
                begin
                    sy_reg   <= s_val;
                    cy_reg   <= c_val;
                    pass_reg <= 1'b1;
                end
            end
            ST_MS:
            begin
                dc_reg <= round_q15(prod_reg);
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    always_comb
    begin
        res.pos_x   = pos_x_reg;
        res.pos_y   = pos_y_reg;
        res.pos_z   = pos_z_reg;
        res.front_x = front_x_reg;
        res.front_y = front_y_reg;
        res.front_z = front_z_reg;
        res.yaw     = yaw_reg;
        res.pitch   = pitch_reg;
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench for the camera pose update block
// Drives rotate and move commands through the input queue, predicts each pose
// in fixed point and checks every popped result in order, across several
// sensitivity and start position settings, with random bursts and stalls.
// ============================================================================

module tb_top;
    import yprc_pkg::*;

    localparam int TRIG_F = 16;

    // ------------------------------------------------------------------------
    // pose predictor and store of expected poses
    // ------------------------------------------------------------------------
    class pose_scoreboard;
        int unsigned sens;
        longint      pos[3];
        int          yaw;
        int          pitch;
        int          front[3];
        int          heading[2];
        res_t        pose_q[$];
        int          errors;
        int          n_checked;
        int          n_rotates;

        function new();
            sens = SENS_RESET;
            pos[0] = 0;
            pos[1] = 0;
            pos[2] = 0;
            yaw = DEG270_Q8;
            pitch = 0;
            errors = 0;
            n_checked = 0;
            n_rotates = 0;
            refresh_vectors();
        endfunction

        function longint round_away(longint v, int sh);
            longint unsigned m;
            m = (v < 0) ? -v : v;
            m = (m + (64'd1 << (sh - 1))) >> sh;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function int to_q15(longint v, int frac);
            longint m;
            m = round_away(v, frac - 15);
            if (m > 32767) m = 32767;
            if (m < -32767) m = -32767;
            return int'(m);
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // series sin/cos of a nonnegative angle in 1/256 degree
        function void trig(int unsigned a, output longint s, output longint c);
            int unsigned q;
            int unsigned r;
            bit swap;
            longint unsigned x;
            longint unsigned p[11];
            longint sr, cr, t;
            a = a % DEG360_Q8;
            q = a / DEG90_Q8;
            r = a % DEG90_Q8;
            swap = 0;
            if (r > DEG45_Q8) begin
                r = DEG90_Q8 - r;
                swap = 1;
            end
            x = (longint'(r) * 74961321 + (64'd1 << (39 - TRIG_F))) >> (40 - TRIG_F);
            p[1] = x;
            for (int k = 2; k <= 10; k++)
                p[k] = (p[k-1] * x) >> TRIG_F;
            sr = longint'(x) - longint'(p[3] / 6) + longint'(p[5] / 120)
               - longint'(p[7] / 5040) + longint'(p[9] / 362880);
            cr = longint'(64'd1 << TRIG_F) - longint'(p[2] / 2) + longint'(p[4] / 24)
               - longint'(p[6] / 720) + longint'(p[8] / 40320)
               - longint'(p[10] / 3628800);
            if (swap) begin
                t = sr;
                sr = cr;
                cr = t;
            end
            case (q)
                0: begin s = sr;  c = cr;  end
                1: begin s = cr;  c = -sr; end
                2: begin s = -sr; c = -cr; end
                default: begin s = -cr; c = sr; end
            endcase
        endfunction

        function void refresh_vectors();
            longint sy, cy, sp, cp;
            trig(yaw, sy, cy);
            trig((pitch < 0) ? -pitch : pitch, sp, cp);
            if (pitch < 0) sp = -sp;
            front[0] = to_q15(cy * cp, 2 * TRIG_F);
            front[1] = to_q15(sp, TRIG_F);
            front[2] = to_q15(sy * cp, 2 * TRIG_F);
            heading[0] = to_q15(cy, TRIG_F);
            heading[1] = to_q15(sy, TRIG_F);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_SENS:    sens = data[15:0];
                REG_START_X: pos[0] = longint'($signed(data));
                REG_START_Y: pos[1] = longint'($signed(data));
                REG_START_Z: pos[2] = longint'($signed(data));
                default: ;
            endcase
        endfunction

        function void note_input(op_t op, logic signed [OFFSET_W-1:0] xo,
                                 logic signed [OFFSET_W-1:0] yo,
                                 logic signed [SPEED_W-1:0] spd);
            longint sp, dc, ds, y, p;
            res_t r;
            sp = longint'(spd);
            dc = round_away(sp * heading[0], 15);
            ds = round_away(sp * heading[1], 15);
            case (op)
                OP_ROTATE: begin
                    n_rotates++;
                    y = yaw + round_away(longint'(xo) * sens, 8);
                    p = pitch + round_away(longint'(yo) * sens, 8);
                    if (p > 22784) p = 22784;
                    if (p < -22784) p = -22784;
                    // zero wraps to 360 and then back to zero
                    if (y <= 0) y += DEG360_Q8;
                    if (y >= DEG360_Q8) y -= DEG360_Q8;
                    yaw = int'(y);
                    pitch = int'(p);
                    refresh_vectors();
                end
                OP_UP:       pos[1] = clamp32(pos[1] + sp);
                OP_DOWN:     pos[1] = clamp32(pos[1] - sp);
                OP_LEFT: begin
                    pos[0] = clamp32(pos[0] + ds);
                    pos[2] = clamp32(pos[2] - dc);
                end
                OP_RIGHT: begin
                    pos[0] = clamp32(pos[0] - ds);
                    pos[2] = clamp32(pos[2] + dc);
                end
                OP_FORWARD: begin
                    pos[0] = clamp32(pos[0] + dc);
                    pos[2] = clamp32(pos[2] + ds);
                end
                OP_BACKWARD: begin
                    pos[0] = clamp32(pos[0] - dc);
                    pos[2] = clamp32(pos[2] - ds);
                end
                default: ;
            endcase
            r.pos_x   = pos[0][31:0];
            r.pos_y   = pos[1][31:0];
            r.pos_z   = pos[2][31:0];
            r.front_x = front[0][15:0];
            r.front_y = front[1][15:0];
            r.front_z = front[2][15:0];
            r.yaw     = yaw[16:0];
            r.pitch   = pitch[15:0];
            pose_q.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t e;
            if (pose_q.size() == 0) begin
                $error("result popped with no pose expected");
                errors++;
                return;
            end
            e = pose_q.pop_front();
            n_checked++;
            if (got.pos_x !== e.pos_x) begin
                $error("pos_x expected %0d got %0d", e.pos_x, got.pos_x); errors++;
            end
            if (got.pos_y !== e.pos_y) begin
                $error("pos_y expected %0d got %0d", e.pos_y, got.pos_y); errors++;
            end
            if (got.pos_z !== e.pos_z) begin
                $error("pos_z expected %0d got %0d", e.pos_z, got.pos_z); errors++;
            end
            if (got.front_x !== e.front_x) begin
                $error("front_x expected %0d got %0d", e.front_x, got.front_x); errors++;
            end
            if (got.front_y !== e.front_y) begin
                $error("front_y expected %0d got %0d", e.front_y, got.front_y); errors++;
            end
            if (got.front_z !== e.front_z) begin
                $error("front_z expected %0d got %0d", e.front_z, got.front_z); errors++;
            end
            if (got.yaw !== e.yaw) begin
                $error("yaw_out expected %0d got %0d", e.yaw, got.yaw); errors++;
            end
            if (got.pitch !== e.pitch) begin
                $error("pitch_out expected %0d got %0d", e.pitch, got.pitch); errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut
    // ------------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic [2:0]                 mode;
    logic signed [OFFSET_W-1:0] x_offset;
    logic signed [OFFSET_W-1:0] y_offset;
    logic signed [SPEED_W-1:0]  speed;
    logic                       empty;
    logic                       pop;
    logic signed [POS_W-1:0]    pos_x, pos_y, pos_z;
    logic signed [VEC_W-1:0]    front_x, front_y, front_z;
    logic [YAW_W-1:0]           yaw_out;
    logic signed [PITCH_W-1:0]  pitch_out;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    pose_scoreboard sb = new();
    int n_items;
    longint unsigned cyc;

    yaw_pitch_camera_pose_update u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .x_offset  (x_offset),
        .y_offset  (y_offset),
        .speed     (speed),
        .empty     (empty),
        .pop       (pop),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .front_x   (front_x),
        .front_y   (front_y),
        .front_z   (front_z),
        .yaw_out   (yaw_out),
        .pitch_out (pitch_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // input transactions are taken into the predictor as they are accepted
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            sb.note_input(op_t'(mode), x_offset, y_offset, speed);
            n_items++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result({pos_x, pos_y, pos_z, front_x, front_y, front_z,
                             yaw_out, pitch_out});
    end

    // receiver stall pattern rotates through always, mostly, rarely and burst pop
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            cyc <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            case ((cyc >> 8) % 4)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 3) != 0);
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= ((cyc % 64) < 8);
            endcase
        end
    end

    task automatic send(op_t op, logic signed [OFFSET_W-1:0] xo,
                        logic signed [OFFSET_W-1:0] yo, logic signed [SPEED_W-1:0] spd);
        push     <= 1'b1;
        mode     <= op;
        x_offset <= xo;
        y_offset <= yo;
        speed    <= spd;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic pause(int n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // sender holds off until every expected pose has come back
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pose_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes; setup drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic setup(logic [15:0] s, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        drain();
        write_reg(REG_SENS, {16'd0, s});
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_START_Z, sz);
        cfg_we <= 1'b0;
    endtask

    task automatic random_items(int count, int rot_pct);
        op_t op;
        logic signed [SPEED_W-1:0] spd;
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                if ($urandom_range(0, 99) < rot_pct)
                    op = OP_ROTATE;
                else
                    op = op_t'($urandom_range(1, 7));
                case ($urandom_range(0, 5))
                    0: spd = {1'b0, {23{1'b1}}};
                    1: spd = {1'b1, 23'd0};
                    2: spd = 24'($urandom);
                    default: spd = $signed(24'($urandom_range(0, 20'hfffff))) - 24'sh80000;
                endcase
                send(op, 9'($urandom), 9'($urandom), spd);
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 20));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        mode      = OP_NONE;
        x_offset  = '0;
        y_offset  = '0;
        speed     = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_SENS;
        cfg_data  = '0;
        n_items   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pose straight after reset, then every operation
        send(OP_NONE, 9'sd0, 9'sd0, 24'sd0);
        send(OP_FORWARD, 9'sd0, 9'sd0, 24'sh010000);
        send(OP_LEFT, 9'sd0, 9'sd0, 24'sh7fffff);
        send(OP_RIGHT, 9'sd0, 9'sd0, -24'sh800000);
        send(OP_UP, 9'sd0, 9'sd0, 24'sh7fffff);
        send(OP_DOWN, 9'sd0, 9'sd0, -24'sh800000);
        send(OP_BACKWARD, 9'sd0, 9'sd0, 24'sh012345);
        send(OP_ROTATE, 9'sd255, -9'sd255, 24'sh7fffff);
        send(OP_ROTATE, -9'sd256, 9'sd255, 24'sd0);
        pause(3);

        // whole-degree steps so that yaw lands on exactly zero
        setup(16'd61440, 32'h7fffffff, 32'h80000000, 32'h7fff0000);
        send(OP_ROTATE, -9'sd144, 9'sd0, 24'sd0);
        send(OP_ROTATE, -9'sd144, 9'sd0, 24'sd0);
        send(OP_ROTATE, 9'sd0, 9'sd255, 24'sd0);
        send(OP_FORWARD, 9'sd0, 9'sd0, 24'sh7fffff);
        send(OP_UP, 9'sd0, 9'sd0, 24'sh7fffff);
        send(OP_DOWN, 9'sd0, 9'sd0, 24'sh7fffff);
        send(OP_ROTATE, 9'sd0, -9'sd255, 24'sd0);
        send(OP_ROTATE, 9'sd90, -9'sd200, 24'sd0);
        send(OP_BACKWARD, 9'sd0, 9'sd0, 24'sh7fffff);
        random_items(110, 30);

        setup(16'd0, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send(OP_ROTATE, 9'sd255, 9'sd255, 24'sd0);
        random_items(100, 20);

        setup(16'hffff, 32'h00000000, 32'h00000000, 32'h00000000);
        random_items(140, 40);

        setup(16'($urandom), $urandom, $urandom, $urandom);
        random_items(140, 30);

        setup(16'd6554, 32'h00010000, 32'hffff0000, 32'h00000000);
        random_items(140, 35);

        push <= 1'b0;
        @(posedge clk);
        while (sb.pose_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("tb_top: %0d commands sent (%0d rotates), %0d poses checked",
                 n_items, sb.n_rotates, sb.n_checked);
        $display("tb_top: 5 register settings incl. zero and full sensitivity, saturated start");
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

### yaw_pitch_camera_pose_update.f
rtl/yprc_pkg.sv
rtl/yprc_front.sv
rtl/yprc_back.sv
rtl/yaw_pitch_camera_pose_update.sv
tb/tb_top.sv
